[design/vp8sp_pkg.sv]
// Shared types, constants and the tap table of the sub-pixel interpolation filter.
package vp8sp_pkg;

	localparam int PIX_W       = 8;
	localparam int PIX_MAX     = 255;
	localparam int TAPS        = 6;
	localparam int FRAC_W      = 3;
	localparam int BW_W        = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int COEF_W      = 9;
	localparam int PROD_W      = 18;
	localparam int SUM_W       = 18;
	localparam int ROUND_BIAS  = 64;
	localparam int ROUND_SHIFT = 7;
	localparam int LEAD_SIX    = 5;
	localparam int LEAD_FOUR   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIRECTION   = 2'd0,
		CFG_FRAC        = 2'd1,
		CFG_SIX_TAP     = 2'd2,
		CFG_BLOCK_WIDTH = 2'd3
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [TAPS-1:0] pix_set_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [TAPS-1:0] coef_set_t;

	// pixels aligned to taps 0..5 plus the row marker
	typedef struct packed {
		pix_set_t pix;
		logic     row_end;
	} filt_in_t;

	// taps listed from tap 5 down to tap 0
	function automatic coef_set_t tap_coefs(input logic [FRAC_W-1:0] frac);
		coef_set_t c;
		case (frac)
			3'd1: c = {coef_t'(0), coef_t'(-1), coef_t'(12), coef_t'(123), coef_t'(-6),
				coef_t'(0)};
			3'd2: c = {coef_t'(1), coef_t'(-8), coef_t'(36), coef_t'(108), coef_t'(-11),
				coef_t'(2)};
			3'd3: c = {coef_t'(0), coef_t'(-6), coef_t'(50), coef_t'(93), coef_t'(-9),
				coef_t'(0)};
			3'd4: c = {coef_t'(3), coef_t'(-16), coef_t'(77), coef_t'(77), coef_t'(-16),
				coef_t'(3)};
			3'd5: c = {coef_t'(0), coef_t'(-9), coef_t'(93), coef_t'(50), coef_t'(-6),
				coef_t'(0)};
			3'd6: c = {coef_t'(2), coef_t'(-11), coef_t'(108), coef_t'(36), coef_t'(-8),
				coef_t'(1)};
			3'd7: c = {coef_t'(0), coef_t'(-6), coef_t'(123), coef_t'(12), coef_t'(-1),
				coef_t'(0)};
			default: c = {coef_t'(0), coef_t'(0), coef_t'(0), coef_t'(128), coef_t'(0),
				coef_t'(0)};
		endcase
		return c;
	endfunction

endpackage

[design/vp8sp_line_store.sv]
// Column-addressed line store: one word of stored rows per column, read-modify-write with forwarding.
module vp8sp_line_store #(
	parameter int DEPTH = 16,
	parameter int WORD_W = 40,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] wb_q;
	logic              fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// hold the last word written, for a read that raced it
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wb_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (rd_addr == wr_addr);
		end
	end

	assign rd_data = fwd_q ? wb_q : rd_q;

	// unwritten words hold unknown bits, so compare them exactly
	a_fwd_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en && rd_addr == wr_addr) |=> (rd_data === $past(wr_data)))
		else $error("line store read missed a same-column write");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!rd_en && !wr_en) |=> (rd_data === $past(rd_data)))
		else $error("line store read data moved without access");

	a_plain_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !wr_en) |=> !fwd_q)
		else $error("line store forwarded without a write");

endmodule

[design/vp8sp_tap_filter.sv]
// Six-tap multiply stage, then sum, round and clamp into the output register.
module vp8sp_tap_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  vp8sp_pkg::filt_in_t           up_item,
	input  logic [vp8sp_pkg::FRAC_W-1:0]  frac_position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vp8sp_pkg::PIX_W-1:0]   pixel_out,
	output logic                          row_end
);
	import vp8sp_pkg::*;

	coef_set_t                 coef;
	logic signed [PROD_W-1:0]  prod_c [TAPS];
	logic signed [PROD_W-1:0]  prod_s2 [TAPS];
	logic                      valid_s2;
	logic                      end_s2;
	logic signed [SUM_W-1:0]   sum_c;
	logic signed [SUM_W-1:0]   biased;
	logic signed [SUM_W-1:0]   shifted;
	logic [PIX_W-1:0]          pix_c;
	logic                      out_valid_q;
	logic [PIX_W-1:0]          pix_q;
	logic                      end_q;
	logic                      en_out;

	assign coef = tap_coefs(frac_position);

	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			prod_c[k] = $signed(coef[k]) * $signed({1'b0, up_item.pix[k]});
		end
	end

	assign en_out   = !out_valid_q || out_ready;
	assign up_ready = !valid_s2 || en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			for (int k = 0; k < TAPS; k++) begin
				prod_s2[k] <= prod_c[k];
			end
			end_s2 <= up_item.row_end;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < TAPS; k++) begin
			sum_c = sum_c + prod_s2[k];
		end
		biased  = sum_c + SUM_W'(ROUND_BIAS);
		shifted = biased >>> ROUND_SHIFT;
		// clamp negative to zero, overflow to full scale
		if (biased[SUM_W-1]) begin
			pix_c = '0;
		end else if (shifted > SUM_W'(PIX_MAX)) begin
			pix_c = PIX_W'(PIX_MAX);
		end else begin
			pix_c = shifted[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && en_out) begin
			pix_q <= pix_c;
			end_q <= end_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_q;
	assign row_end   = end_q;

	a_bubble_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> up_ready)
		else $error("filter stalled with an empty output register");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !en_out) |=> (valid_s2 && $stable(end_s2)))
		else $error("filter product stage lost a stalled item");

	a_stage_load: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && up_ready) |=> valid_s2)
		else $error("filter dropped an accepted item");

endmodule

[design/vp8_subpixel_interpolation_filter.sv]
// Top level of the VP8 six-tap / four-tap sub-pixel interpolation pass.
//
// Takes one source pixel per cycle and sustains one pixel per cycle in either direction
// unless out_ready holds back the output; an accepted pixel's result is registered after
// the line-store read, the tap products and sum/round/clamp. The horizontal pass slides a
// five-pixel shift line plus the incoming pixel; the vertical pass keeps, per column,
// one word of the five previous rows in a memory of MAX_WIDTH words with one read and
// one write port, read-modified-written one column per pixel, with the pending write
// forwarded when the next pixel hits the same column. Rows are block_width pixels wide
// in the vertical pass, and block_width+5 (six-tap) or block_width+3 (four-tap) in the
// horizontal pass; margin pixels and lead rows give no result. The line store needs no
// clearing after reset: read data is used only after the lead rows have written the column.
// block_start clears the column and row counters, not the stored pixels.
module vp8_subpixel_interpolation_filter #(
	parameter int MAX_WIDTH = 16,
	parameter int STORED_ROWS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [vp8sp_pkg::PIX_W-1:0]       pixel_in,
	input  logic                              block_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [vp8sp_pkg::PIX_W-1:0]       pixel_out,
	output logic                              row_end,
	input  logic                              cfg_we,
	input  logic [vp8sp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vp8sp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import vp8sp_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH + LEAD_SIX);
	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(STORED_ROWS + 1);
	localparam int WORD_W = STORED_ROWS * PIX_W;

	// configuration
	logic              direction_q;
	logic [FRAC_W-1:0] frac_q;
	logic              six_tap_q;
	logic [BW_W-1:0]   bw_q;

	// counters and horizontal window
	logic [CW-1:0]     col_cnt_q;
	logic [RW-1:0]     row_cnt_q;
	pix_t              win_q [LEAD_SIX];

	// stage 0 decode
	logic              accept;
	logic [CW-1:0]     eff_col;
	logic [RW-1:0]     eff_row;
	logic [CW-1:0]     lead;
	logic [RW-1:0]     lead_row;
	logic [CW-1:0]     width;
	logic [CW-1:0]     last;
	logic [CW-1:0]     col;
	logic              end0;
	logic              emit0;
	pix_set_t          hpix;

	// stage 1: line-store data arrives
	logic              valid_s1;
	logic              dir_s1;
	logic              emit_s1;
	logic              end_s1;
	pix_t              px_s1;
	logic [AW-1:0]     addr_s1;
	pix_set_t          hpix_s1;
	logic              leave1;
	logic              en1;

	logic [WORD_W-1:0] word;
	pix_set_t          vpix;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;

	filt_in_t          up_item;
	logic              up_valid;
	logic              up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			frac_q      <= FRAC_W'(1);
			six_tap_q   <= 1'b1;
			bw_q        <= BW_W'(16);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DIRECTION:   direction_q <= cfg_data[0];
				CFG_FRAC:        frac_q      <= cfg_data[FRAC_W-1:0];
				CFG_SIX_TAP:     six_tap_q   <= cfg_data[0];
				CFG_BLOCK_WIDTH: bw_q        <= cfg_data[BW_W-1:0];
				default:         ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		eff_col  = block_start ? '0 : col_cnt_q;
		eff_row  = block_start ? '0 : row_cnt_q;
		lead     = six_tap_q ? CW'(LEAD_SIX) : CW'(LEAD_FOUR);
		lead_row = six_tap_q ? RW'(LEAD_SIX) : RW'(LEAD_FOUR);
		if (bw_q == '0) begin
			width = CW'(1);
		end else if (int'(bw_q) > MAX_WIDTH) begin
			width = CW'(MAX_WIDTH);
		end else begin
			width = CW'(bw_q);
		end
		last  = direction_q ? width - CW'(1) : width + lead - CW'(1);
		// a counter left past the row end takes the last column
		col   = (eff_col > last) ? last : eff_col;
		end0  = (col >= last);
		emit0 = direction_q ? (eff_row >= lead_row) : (col >= lead);
		if (six_tap_q) begin
			hpix = {pixel_in, win_q[4], win_q[3], win_q[2], win_q[1], win_q[0]};
		end else begin
			hpix = {pix_t'(0), pixel_in, win_q[4], win_q[3], win_q[2], pix_t'(0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			col_cnt_q <= end0 ? '0 : col + CW'(1);
			if (direction_q && end0 && eff_row < RW'(STORED_ROWS)) begin
				row_cnt_q <= eff_row + RW'(1);
			end else begin
				row_cnt_q <= eff_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LEAD_SIX; k++) begin
				win_q[k] <= '0;
			end
		end else if (accept && !direction_q) begin
			for (int k = 0; k < LEAD_SIX - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[LEAD_SIX-1] <= pixel_in;
		end
	end

	// stage 1 advances when empty or when its item moves on
	assign leave1   = valid_s1 && (!emit_s1 || up_ready);
	assign en1      = !valid_s1 || leave1;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dir_s1  <= direction_q;
			emit_s1 <= emit0;
			end_s1  <= end0;
			px_s1   <= pixel_in;
			addr_s1 <= col[AW-1:0];
			hpix_s1 <= hpix;
		end
	end

	vp8sp_line_store #(
		.DEPTH  (MAX_WIDTH),
		.WORD_W (WORD_W)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && direction_q),
		.rd_addr (col[AW-1:0]),
		.rd_data (word),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	always_comb begin
		if (six_tap_q) begin
			for (int k = 0; k < LEAD_SIX; k++) begin
				vpix[k] = word[(STORED_ROWS - LEAD_SIX + k) * PIX_W +: PIX_W];
			end
			vpix[LEAD_SIX] = px_s1;
		end else begin
			vpix[0] = '0;
			for (int k = 0; k < LEAD_FOUR; k++) begin
				vpix[k+1] = word[(STORED_ROWS - LEAD_FOUR + k) * PIX_W +: PIX_W];
			end
			vpix[LEAD_FOUR+1] = px_s1;
			vpix[TAPS-1]      = '0;
		end
	end

	// shift the column's rows, oldest out, new pixel in
	assign wr_en   = leave1 && dir_s1;
	assign wr_data = {px_s1, word[WORD_W-1:PIX_W]};

	assign up_valid        = valid_s1 && emit_s1;
	assign up_item.pix     = dir_s1 ? vpix : hpix_s1;
	assign up_item.row_end = end_s1;

	vp8sp_tap_filter u_tap_filter (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (up_valid),
		.up_ready      (up_ready),
		.up_item       (up_item),
		.frac_position (frac_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_out     (pixel_out),
		.row_end       (row_end)
	);

	a_accept_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while the output register is empty");

	a_row_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= RW'(STORED_ROWS))
		else $error("row counter ran past saturation");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !leave1) |=> (valid_s1 && $stable(addr_s1) && $stable(px_s1)))
		else $error("stalled line-store stage lost its item");

endmodule
